/* hw/rtl/vms_pkg.sv */
// Package: constants, types and helpers shared by the metabolic stimulus pipeline.
`default_nettype none
package vms_pkg;
   localparam int FRACTION_BITS = 16;
   localparam int FLOW_W = 40;
   localparam int HCT_W = 16;
   localparam int GAIN_W = 20;
   localparam int STIM_W = 56;
   localparam int DEN_W = 56;
   localparam int NUM_W = 57;
   localparam int LEAD_W = 6;
   localparam int LOG_W = LEAD_W + FRACTION_BITS;
   localparam int MANT_W = 33;
   localparam logic [31:0] LOG10_OF_2_Q32 = 32'd1292913987;

   localparam logic [1:0] CSR_REF_FLOW = 2'd0;
   localparam logic [1:0] CSR_GAIN = 2'd1;
   localparam logic [1:0] CSR_MAX_STIM = 2'd2;

   // special-case code carried down the pipe
   typedef enum logic [1:0] {
      KIND_NORMAL = 2'd0,
      KIND_ZERO = 2'd1,
      KIND_MAX = 2'd2
   } kind_type;

   // one log2 evaluation in flight
   typedef struct packed {
      logic [LOG_W-1:0] res;
      logic [MANT_W-1:0] mant;
   } log_lane_type;

   // leading-one index of a 57-bit word
   function automatic logic [LEAD_W-1:0] lead_one(input logic [NUM_W-1:0] v);
      logic [LEAD_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < NUM_W; i++) begin
         if (v[i]) idx = LEAD_W'(i);
      end
      return idx;
   endfunction

   // normalize to Q1.31 with leading one at bit 31
   function automatic logic [MANT_W-1:0] normalize(input logic [NUM_W-1:0] v,
                                                   input logic [LEAD_W-1:0] lead);
      logic [NUM_W+31:0] wide;
      wide = {32'd0, v} << 31;
      return MANT_W'(wide >> lead);
   endfunction

   // one squaring step of the log2 fraction
   function automatic log_lane_type log_step(input log_lane_type ln, input int bitpos);
      logic [65:0] sq;
      logic [MANT_W-1:0] m;
      log_lane_type o;
      sq = 66'(ln.mant) * 66'(ln.mant);
      m = MANT_W'(sq >> 31);
      o = ln;
      if (m[32]) begin
         m = m >> 1;
         o.res[bitpos] = 1'b1;
      end
      o.mant = m;
      return o;
   endfunction
endpackage
`default_nettype wire

/* hw/rtl/vessel_metabolic_stimulus_unit.sv */
// Top level of the vessel metabolic stimulus pipeline.
// One transaction per cycle unless stalled: each segment's stimulus passes
// through 3 front stages, 16 log2 squaring stages and 3 back stages, the last
// of which is the output register. The whole pipe advances together and halts
// while rsp_stall holds a valid result; a stall loses nothing. The user must
// write registers through csr_ only while the pipe is empty (not enforced).
`default_nettype none
module vessel_metabolic_stimulus_unit import vms_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_stall,
   input  wire logic [FLOW_W-1:0] req_flow_rate,
   input  wire logic [HCT_W-1:0] req_haematocrit,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output logic [STIM_W-1:0] rsp_stimulus,
   input  wire logic csr_write,
   input  wire logic [1:0] csr_index,
   input  wire logic [STIM_W-1:0] csr_data
);
   logic [FLOW_W-1:0] ref_ff;
   logic [GAIN_W-1:0] gain_ff;
   logic [STIM_W-1:0] max_ff;
   logic adv;
   logic f_valid, l_valid;
   kind_type f_kind, l_kind;
   log_lane_type f_a, f_b;
   logic [LOG_W-1:0] l_la, l_lb;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff <= 40'd6666000;
         gain_ff <= 20'd54395;
         max_ff <= 56'd655360000000000;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_REF_FLOW: ref_ff <= csr_data[FLOW_W-1:0];
            CSR_GAIN: gain_ff <= csr_data[GAIN_W-1:0];
            CSR_MAX_STIM: max_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign adv = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   vms_front u_front (
      .clock, .reset, .adv, .in_valid(req_valid), .flow(req_flow_rate),
      .hct(req_haematocrit), .ref_flow(ref_ff), .out_valid(f_valid),
      .out_kind(f_kind), .out_a(f_a), .out_b(f_b)
   );

   vms_log u_log (
      .clock, .reset, .adv, .in_valid(f_valid), .in_kind(f_kind), .in_a(f_a),
      .in_b(f_b), .out_valid(l_valid), .out_kind(l_kind), .out_la(l_la),
      .out_lb(l_lb)
   );

   vms_back u_back (
      .clock, .reset, .adv, .in_valid(l_valid), .in_kind(l_kind), .la(l_la),
      .lb(l_lb), .gain(gain_ff), .max_stim(max_ff), .out_valid(rsp_valid),
      .out_stim(rsp_stimulus)
   );
endmodule
`default_nettype wire

/* hw/rtl/vms_front.sv */
// Front stages: magnitude, product with haematocrit, leading-one normalize.
`default_nettype none
module vms_front import vms_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic adv,
   input  wire logic in_valid,
   input  wire logic [FLOW_W-1:0] flow,
   input  wire logic [HCT_W-1:0] hct,
   input  wire logic [FLOW_W-1:0] ref_flow,
   output logic out_valid,
   output kind_type out_kind,
   output log_lane_type out_a,
   output log_lane_type out_b
);
   logic v1_ff, v2_ff;
   kind_type k1_ff, k2_ff;
   logic [FLOW_W-1:0] mag_in, mag_ff;
   logic [HCT_W-1:0] hct_ff;
   logic [FLOW_W-1:0] ref_ff;
   logic [DEN_W-1:0] den_in;
   logic [NUM_W-1:0] num_in, num_ff, den_ff;
   logic [LEAD_W-1:0] la, lb;

   assign mag_in = flow[FLOW_W-1] ? (~flow + 1'b1) : flow;

   // stage 1: magnitude and classify
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= in_valid;
      if (adv) begin
         mag_ff <= mag_in;
         hct_ff <= hct;
         ref_ff <= ref_flow;
         k1_ff <= (mag_in == '0) ? KIND_ZERO : (hct == '0) ? KIND_MAX : KIND_NORMAL;
      end
   end

   // stage 2: product and log argument
   assign den_in = DEN_W'(mag_ff) * DEN_W'(hct_ff);
   assign num_in = {1'b0, ref_ff, 16'd0} + NUM_W'(den_in);
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
      if (adv) begin
         k2_ff <= k1_ff;
         num_ff <= num_in;
         den_ff <= NUM_W'(den_in);
      end
   end

   // stage 3: normalize both operands
   assign la = lead_one(num_ff);
   assign lb = lead_one(den_ff);
   always_ff @(posedge clock) begin
      if (reset) out_valid <= 1'b0;
      else if (adv) out_valid <= v2_ff;
      if (adv) begin
         out_kind <= k2_ff;
         out_a.res <= {la, FRACTION_BITS'(0)};
         out_a.mant <= normalize(num_ff, la);
         out_b.res <= {lb, FRACTION_BITS'(0)};
         out_b.mant <= normalize(den_ff, lb);
      end
   end
endmodule
`default_nettype wire

/* hw/rtl/vms_log.sv */
// Log2 fraction pipeline: one squaring step per stage for two lanes.
`default_nettype none
module vms_log import vms_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic adv,
   input  wire logic in_valid,
   input  wire kind_type in_kind,
   input  wire log_lane_type in_a,
   input  wire log_lane_type in_b,
   output logic out_valid,
   output kind_type out_kind,
   output logic [LOG_W-1:0] out_la,
   output logic [LOG_W-1:0] out_lb
);
   logic v_ff [FRACTION_BITS];
   kind_type k_ff [FRACTION_BITS];
   log_lane_type a_ff [FRACTION_BITS];
   log_lane_type b_ff [FRACTION_BITS];

   // stage s produces fraction bit FRACTION_BITS-1-s
   for (genvar s = 0; s < FRACTION_BITS; s++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) v_ff[s] <= 1'b0;
         else if (adv) v_ff[s] <= (s == 0) ? in_valid : v_ff[s == 0 ? 0 : s-1];
         if (adv) begin
            if (s == 0) begin
               k_ff[s] <= in_kind;
               a_ff[s] <= log_step(in_a, FRACTION_BITS-1);
               b_ff[s] <= log_step(in_b, FRACTION_BITS-1);
            end else begin
               k_ff[s] <= k_ff[s == 0 ? 0 : s-1];
               a_ff[s] <= log_step(a_ff[s == 0 ? 0 : s-1], FRACTION_BITS-1-s);
               b_ff[s] <= log_step(b_ff[s == 0 ? 0 : s-1], FRACTION_BITS-1-s);
            end
         end
      end
   end

   assign out_valid = v_ff[FRACTION_BITS-1];
   assign out_kind = k_ff[FRACTION_BITS-1];
   assign out_la = a_ff[FRACTION_BITS-1].res;
   assign out_lb = b_ff[FRACTION_BITS-1].res;
endmodule
`default_nettype wire

/* hw/rtl/vms_back.sv */
// Back stages: log difference, log10 scaling, gain, special-case select.
`default_nettype none
module vms_back import vms_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic adv,
   input  wire logic in_valid,
   input  wire kind_type in_kind,
   input  wire logic [LOG_W-1:0] la,
   input  wire logic [LOG_W-1:0] lb,
   input  wire logic [GAIN_W-1:0] gain,
   input  wire logic [STIM_W-1:0] max_stim,
   output logic out_valid,
   output logic [STIM_W-1:0] out_stim
);
   logic v1_ff, v2_ff;
   kind_type k1_ff, k2_ff;
   logic [LOG_W-1:0] diff_ff;
   logic [LOG_W+31:0] prod;
   logic [LOG_W-1:0] l10_ff;
   logic [LOG_W+GAIN_W-1:0] sprod;

   // difference, clamped at zero
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= in_valid;
      if (adv) begin
         k1_ff <= in_kind;
         diff_ff <= (la > lb) ? la - lb : '0;
      end
   end

   // scale by log10(2)
   assign prod = (LOG_W+32)'(diff_ff) * (LOG_W+32)'(LOG10_OF_2_Q32);
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
      if (adv) begin
         k2_ff <= k1_ff;
         l10_ff <= LOG_W'(prod >> 32);
      end
   end

   // gain and result select
   assign sprod = (LOG_W+GAIN_W)'(l10_ff) * (LOG_W+GAIN_W)'(gain);
   always_ff @(posedge clock) begin
      if (reset) out_valid <= 1'b0;
      else if (adv) out_valid <= v2_ff;
      if (adv) begin
         unique case (k2_ff)
            KIND_ZERO: out_stim <= '0;
            KIND_MAX: out_stim <= max_stim;
            default: out_stim <= STIM_W'(sprod >> FRACTION_BITS);
         endcase
      end
   end
endmodule
`default_nettype wire

/* dv/tb_vessel_metabolic_stimulus_unit.sv */
// Self-checking testbench for the vessel metabolic stimulus pipeline.
`default_nettype none
module tb_vessel_metabolic_stimulus_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import vms_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int PIPE_LATENCY = 22;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [FLOW_W-1:0] req_flow_rate = '0;
   logic [HCT_W-1:0] req_haematocrit = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [STIM_W-1:0] rsp_stimulus;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = '0;
   logic [STIM_W-1:0] csr_data = '0;

   // shadow copy of the configuration registers
   logic [39:0] ref_flow_q;
   logic [19:0] gain_q;
   logic [55:0] max_stim_q;

   logic [STIM_W-1:0] stimulus_due[$];
   int fail_count = 0;
   int idle_cycles = 0;
   bit stim_done = 1'b0;

   // directed row: flow, haematocrit, typed-in stimulus when known
   typedef struct {
      logic [FLOW_W-1:0] flow;
      logic [HCT_W-1:0] hct;
      bit known;
      logic [STIM_W-1:0] stim;
   } seg_row_type;

   seg_row_type seg_table[$];

   vessel_metabolic_stimulus_unit dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // log2 with 16 fraction bits by repeated squaring of a Q1.31 mantissa
   function automatic logic [63:0] log2_fixed(input logic [63:0] v);
      int lead;
      logic [63:0] m;
      logic [63:0] res;
      logic [127:0] sq;
      lead = 0;
      for (int i = 0; i < 64; i++) if (v[i]) lead = i;
      if (lead >= 31) m = v >> (lead - 31);
      else m = v << (31 - lead);
      res = 64'(lead) << FRACTION_BITS;
      for (int i = FRACTION_BITS - 1; i >= 0; i--) begin
         sq = 128'(m) * 128'(m);
         m = 64'(sq >> 31);
         if (m >= 64'h1_0000_0000) begin
            m = m >> 1;
            res[i] = 1'b1;
         end
      end
      return res;
   endfunction

   function automatic logic [STIM_W-1:0] stimulus_of(input logic [FLOW_W-1:0] flow,
                                                      input logic [HCT_W-1:0] hct);
      logic [39:0] mag;
      logic [63:0] den, num, la, lb, diff, l10;
      logic [127:0] prod;
      mag = flow[FLOW_W-1] ? 40'(-flow) : flow;
      if (mag == 0) return '0;
      if (hct == 0) return max_stim_q;
      den = 64'(mag) * 64'(hct);
      num = (64'(ref_flow_q) << 16) + den;
      la = log2_fixed(num);
      lb = log2_fixed(den);
      diff = (la > lb) ? la - lb : 64'd0;
      prod = 128'(diff) * 128'(LOG10_OF_2_Q32);
      l10 = 64'(prod >> 32);
      prod = (128'(gain_q) * 128'(l10)) >> FRACTION_BITS;
      if (prod > 128'({STIM_W{1'b1}})) return {STIM_W{1'b1}};
      return STIM_W'(prod);
   endfunction

   // configuration write, only while the pipe is empty
   task automatic csr_put(input logic [1:0] idx, input logic [STIM_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_REF_FLOW: ref_flow_q = value[39:0];
         CSR_GAIN: gain_q = value[19:0];
         CSR_MAX_STIM: max_stim_q = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic wait_drain();
      while (stimulus_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // one segment transaction; expectation queued at acceptance
   task automatic send_segment(input logic [FLOW_W-1:0] flow, input logic [HCT_W-1:0] hct,
                               input bit known, input logic [STIM_W-1:0] stim);
      int g;
      g = gap_len();
      if (g != 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_flow_rate <= flow;
      req_haematocrit <= hct;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      stimulus_due.push_back(known ? stim : stimulus_of(flow, hct));
   endtask

   function automatic logic [FLOW_W-1:0] rand_flow();
      logic [FLOW_W-1:0] f;
      f = 40'({$urandom(), $urandom()});
      case ($urandom_range(0, 5))
         0: f = f >> $urandom_range(0, 39);
         1: f = -(f >> $urandom_range(0, 39));
         2: f = 40'($urandom_range(0, 1000)) - 40'd500;
         default: ;
      endcase
      return f;
   endfunction

   function automatic logic [HCT_W-1:0] rand_hct();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(1, 20));
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic random_phase(input int count);
      for (int i = 0; i < count; i++) send_segment(rand_flow(), rand_hct(), 1'b0, '0);
      req_valid <= 1'b0;
      wait_drain();
   endtask

   // result checker and receiver stalls
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (stimulus_due.size() == 0) begin
            $error("unexpected stimulus transaction: actual %0h", rsp_stimulus);
            fail_count++;
         end else begin
            logic [STIM_W-1:0] want;
            want = stimulus_due.pop_front();
            if (want !== rsp_stimulus) begin
               $error("stimulus mismatch: expected %0h actual %0h", want, rsp_stimulus);
               fail_count++;
            end
         end
      end
   end

   initial begin
      int g;
      forever begin
         g = gap_len();
         rsp_stall <= (g != 0);
         repeat (g == 0 ? $urandom_range(1, 12) : g) @(posedge clock);
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset || stim_done)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      ref_flow_q = 40'd6666000;
      gain_q = 20'd54395;
      max_stim_q = 56'd655360000000000;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows: zero flow, zero haematocrit, extremes
      seg_table.push_back('{40'd0, 16'hFFFF, 1'b1, 56'd0});
      seg_table.push_back('{40'd0, 16'd0, 1'b1, 56'd0});
      seg_table.push_back('{40'd1, 16'd0, 1'b1, 56'd655360000000000});
      seg_table.push_back('{40'h80_0000_0000, 16'd0, 1'b1, 56'd655360000000000});
      seg_table.push_back('{40'h80_0000_0000, 16'hFFFF, 1'b0, '0});
      seg_table.push_back('{40'h7F_FFFF_FFFF, 16'hFFFF, 1'b0, '0});
      seg_table.push_back('{40'hFF_FFFF_FFFF, 16'd1, 1'b0, '0});
      seg_table.push_back('{40'd1, 16'd1, 1'b0, '0});
      seg_table.push_back('{40'd1, 16'hFFFF, 1'b0, '0});
      seg_table.push_back('{40'd6666000, 16'h8000, 1'b0, '0});
      seg_table.push_back('{-40'd6666000, 16'h5555, 1'b0, '0});
      seg_table.push_back('{40'h55_5555_5555, 16'hAAAA, 1'b0, '0});
      seg_table.push_back('{40'hAA_AAAA_AAAA, 16'h5555, 1'b0, '0});
      foreach (seg_table[i])
         send_segment(seg_table[i].flow, seg_table[i].hct, seg_table[i].known,
                      seg_table[i].stim);
      req_valid <= 1'b0;
      wait_drain();
      random_phase(150);

      // extreme settings: largest reference, gain and max stimulus
      csr_put(CSR_REF_FLOW, {STIM_W{1'b1}});
      csr_put(CSR_GAIN, {STIM_W{1'b1}});
      csr_put(CSR_MAX_STIM, {STIM_W{1'b1}});
      csr_put(CSR_UNUSED, 56'h12345);
      send_segment(40'd5, 16'd0, 1'b1, {STIM_W{1'b1}});
      random_phase(150);

      // zero reference flow, zero max stimulus and zero gain give zero stimulus
      csr_put(CSR_REF_FLOW, 56'd0);
      csr_put(CSR_MAX_STIM, 56'd0);
      send_segment(40'd12345, 16'h1234, 1'b1, 56'd0);
      send_segment(40'd7, 16'd0, 1'b1, 56'd0);
      req_valid <= 1'b0;
      wait_drain();
      csr_put(CSR_GAIN, 56'd0);
      random_phase(50);

      // random mid settings
      for (int p = 0; p < 2; p++) begin
         csr_put(CSR_REF_FLOW, 56'({$urandom(), $urandom()}) >> $urandom_range(16, 40));
         csr_put(CSR_GAIN, 56'($urandom()));
         csr_put(CSR_MAX_STIM, 56'({$urandom(), $urandom()}));
         random_phase(120);
      end

      repeat (PIPE_LATENCY + 8) @(posedge clock);
      stim_done = 1'b1;
      if (fail_count == 0 && stimulus_due.size() == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule
`default_nettype wire
